[rtl/vfcm_pkg.sv]
// Shared types, codes and constant tables of the voxel face-cull mesher.
// Used by the top level and the vertex formatter; depends on nothing.
`default_nettype none

package vfcm_pkg;

  localparam int CELL_W     = 4;   // local cell coordinate
  localparam int ID_W       = 8;   // block and texture ids
  localparam int CPOS_W     = 12;  // chunk position register
  localparam int POS_W      = 18;  // vertex position in half units
  localparam int SHADE_W    = 4;
  localparam int TEX_W      = 9;
  localparam int FACE_W     = 3;
  localparam int CORNER_W   = 2;
  localparam int VIDX_W     = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int NUM_FACES  = 6;

  localparam int CHUNK_EDGE_DEF = 16;

  localparam int IN_DATA_W  = 24;  // 23 field bits padded to bytes
  localparam int OUT_DATA_W = 88;  // 87 field bits padded to bytes

  typedef enum logic [KIND_W-1:0] {
    KIND_CHUNK_WR  = 2'd0,
    KIND_BORDER_WR = 2'd1,
    KIND_MESH      = 2'd2,
    KIND_START     = 2'd3
  } vfcm_kind_t;

  localparam logic [FACE_W-1:0] FACE_NX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd2;
  localparam logic [FACE_W-1:0] FACE_PX = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd4;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_AIR       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRASS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRASS_TOP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Z     = 3'd6;

  localparam logic [ID_W-1:0] AIR_RST       = 8'd0;
  localparam logic [ID_W-1:0] GRASS_RST     = 8'd2;
  localparam logic [ID_W-1:0] GRASS_TOP_RST = 8'd3;
  localparam logic [ID_W-1:0] DIRT_RST      = 8'd1;

  typedef struct packed {
    logic [ID_W-1:0]          air;
    logic [ID_W-1:0]          grass;
    logic [ID_W-1:0]          grass_top;
    logic [ID_W-1:0]          dirt;
    logic signed [CPOS_W-1:0] pos_x;
    logic signed [CPOS_W-1:0] pos_y;
    logic signed [CPOS_W-1:0] pos_z;
  } vfcm_cfg_t;

  // one vertex to format
  typedef struct packed {
    logic [FACE_W-1:0]   face;
    logic [CORNER_W-1:0] corner;
    logic [ID_W-1:0]     blk;
    logic [CELL_W-1:0]   cx;
    logic [CELL_W-1:0]   cy;
    logic [CELL_W-1:0]   cz;
  } vfcm_vtx_req_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic [SHADE_W-1:0] shade;
    logic [TEX_W-1:0]   tex_column;
    logic               tex_v;
  } vfcm_vtx_t;

  function automatic logic [1:0] face_axis(input logic [FACE_W-1:0] face);
    logic [1:0] ax;
    case (face)
      FACE_NX, FACE_PX: ax = AXIS_X;
      FACE_NY, FACE_PY: ax = AXIS_Y;
      default:          ax = AXIS_Z;
    endcase
    return ax;
  endfunction

  function automatic logic [SHADE_W-1:0] face_shade(input logic [FACE_W-1:0] face);
    logic [SHADE_W-1:0] s;
    case (face)
      FACE_NX: s = 4'd7;
      FACE_NY: s = 4'd4;
      FACE_NZ: s = 4'd6;
      FACE_PX: s = 4'd7;
      FACE_PY: s = 4'd10;
      FACE_PZ: s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // corner offset signs, bit 0 x, bit 1 y, bit 2 z; set means +1, clear -1
  function automatic logic [2:0] corner_signs(input logic [FACE_W-1:0]   face,
                                              input logic [CORNER_W-1:0] corner);
    logic [2:0] s;
    case ({face, corner})
      {FACE_NX, 2'd0}: s = 3'b010;
      {FACE_NX, 2'd1}: s = 3'b110;
      {FACE_NX, 2'd2}: s = 3'b100;
      {FACE_NX, 2'd3}: s = 3'b000;
      {FACE_NY, 2'd0}: s = 3'b100;
      {FACE_NY, 2'd1}: s = 3'b101;
      {FACE_NY, 2'd2}: s = 3'b001;
      {FACE_NY, 2'd3}: s = 3'b000;
      {FACE_NZ, 2'd0}: s = 3'b010;
      {FACE_NZ, 2'd1}: s = 3'b011;
      {FACE_NZ, 2'd2}: s = 3'b001;
      {FACE_NZ, 2'd3}: s = 3'b000;
      {FACE_PX, 2'd0}: s = 3'b011;
      {FACE_PX, 2'd1}: s = 3'b111;
      {FACE_PX, 2'd2}: s = 3'b101;
      {FACE_PX, 2'd3}: s = 3'b001;
      {FACE_PY, 2'd0}: s = 3'b110;
      {FACE_PY, 2'd1}: s = 3'b111;
      {FACE_PY, 2'd2}: s = 3'b011;
      {FACE_PY, 2'd3}: s = 3'b010;
      {FACE_PZ, 2'd0}: s = 3'b110;
      {FACE_PZ, 2'd1}: s = 3'b111;
      {FACE_PZ, 2'd2}: s = 3'b101;
      {FACE_PZ, 2'd3}: s = 3'b100;
      default:         s = 3'b000;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/voxel_face_cull_mesher.sv]
// Voxel face-cull mesher top level: cell stores, sequencer and vertex output.
// Depends on vfcm_pkg, vfcm_ram and vfcm_vertex.
//
//   channel | dir | handshake                 | payload
//   in_     | in  | in_tvalid / in_tready     | in_tuser kind, in_tdata cell and value
//   out_    | out | out_tvalid / out_tready   | out_tdata vertex, out_tlast end of cell
//   cfg_    | in  | cfg_we (no wait)          | cfg_index, cfg_wdata
//
// Write and start items never leave S_IDLE. A mesh item reads and checks its cell,
// reads and compares its six neighbours (one read port per store, address then
// compare), then emits four corners per visible face: the single vertex unit
// formats one corner a cycle, and out_tready low stalls vertex output in place.
// Air or out-of-range cells finish early. Reset sets the registers to their
// defaults and clears the vertex counter; the cell stores are not cleared.
`default_nettype none

module voxel_face_cull_mesher
  import vfcm_pkg::*;
#(
  parameter int CHUNK_EDGE = CHUNK_EDGE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [3:0] cell_x, [7:4] cell_y, [11:8] cell_z, [14:12] border_side,
  // [22:15] block_value, [23] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  wire logic [KIND_W-1:0]     in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [15:0] vertex_index, [33:16] pos_x_half, [51:34] pos_y_half,
  // [69:52] pos_z_half, [73:70] shade_tenths, [82:74] tex_column,
  // [83] tex_v, [86:84] face_dir, [87] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PLANE        = CHUNK_EDGE * CHUNK_EDGE;
  localparam int CUBE_DEPTH   = PLANE * CHUNK_EDGE;
  localparam int BORDER_DEPTH = NUM_FACES * PLANE;
  localparam int CUBE_AW      = $clog2(CUBE_DEPTH);
  localparam int BORDER_AW    = $clog2(BORDER_DEPTH);
  localparam int EW           = $clog2(CHUNK_EDGE + 1);
  localparam int CMP_W        = (EW > CELL_W + 1) ? EW : CELL_W + 1;
  localparam logic [CMP_W-1:0] EDGE_C  = CMP_W'(CHUNK_EDGE);
  localparam logic [CMP_W-1:0] EDGE_M1 = CMP_W'(CHUNK_EDGE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL_RD,
    S_CELL_CHK,
    S_NB_RD,
    S_NB_CHK,
    S_EMIT
  } state_t;

  function automatic logic [CUBE_AW-1:0] cube_addr(input logic [CMP_W-1:0] x,
                                                   input logic [CMP_W-1:0] y,
                                                   input logic [CMP_W-1:0] z);
    return CUBE_AW'(x * PLANE + y * CHUNK_EDGE + z);
  endfunction

  function automatic logic [BORDER_AW-1:0] plane_addr(input logic [FACE_W-1:0] side,
                                                      input logic [CMP_W-1:0]  x,
                                                      input logic [CMP_W-1:0]  y,
                                                      input logic [CMP_W-1:0]  z);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    case (face_axis(side))
      AXIS_X: begin
        a = y;
        b = z;
      end
      AXIS_Y: begin
        a = x;
        b = z;
      end
      default: begin
        a = x;
        b = y;
      end
    endcase
    return BORDER_AW'(side * PLANE + a * CHUNK_EDGE + b);
  endfunction

  // configuration registers
  vfcm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.air       <= AIR_RST;
      cfg_r.grass     <= GRASS_RST;
      cfg_r.grass_top <= GRASS_TOP_RST;
      cfg_r.dirt      <= DIRT_RST;
      cfg_r.pos_x     <= '0;
      cfg_r.pos_y     <= '0;
      cfg_r.pos_z     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AIR:       cfg_r.air       <= cfg_wdata[ID_W-1:0];
        REG_GRASS:     cfg_r.grass     <= cfg_wdata[ID_W-1:0];
        REG_GRASS_TOP: cfg_r.grass_top <= cfg_wdata[ID_W-1:0];
        REG_DIRT:      cfg_r.dirt      <= cfg_wdata[ID_W-1:0];
        REG_POS_X:     cfg_r.pos_x     <= cfg_wdata[CPOS_W-1:0];
        REG_POS_Y:     cfg_r.pos_y     <= cfg_wdata[CPOS_W-1:0];
        REG_POS_Z:     cfg_r.pos_z     <= cfg_wdata[CPOS_W-1:0];
        default: ;
      endcase
    end
  end

  // input item fields
  vfcm_kind_t        in_kind;
  logic [CELL_W-1:0] in_cx, in_cy, in_cz;
  logic [FACE_W-1:0] in_side;
  logic [ID_W-1:0]   in_value;
  logic [CMP_W-1:0]  in_wx, in_wy, in_wz;
  logic              in_fire;
  logic              in_range;

  assign in_kind  = vfcm_kind_t'(in_tuser);
  assign in_cx    = in_tdata[3:0];
  assign in_cy    = in_tdata[7:4];
  assign in_cz    = in_tdata[11:8];
  assign in_side  = in_tdata[14:12];
  assign in_value = in_tdata[22:15];
  assign in_wx    = CMP_W'(in_cx);
  assign in_wy    = CMP_W'(in_cy);
  assign in_wz    = CMP_W'(in_cz);
  assign in_fire  = in_tvalid && in_tready;
  assign in_range = (in_wx < EDGE_C) && (in_wy < EDGE_C) && (in_wz < EDGE_C);

  // sequencer registers
  state_t              state_r, state_nxt;
  logic [CELL_W-1:0]   cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [ID_W-1:0]     blk_r, blk_nxt;
  logic [FACE_W-1:0]   face_r, face_nxt;
  logic [NUM_FACES-1:0] pend_r, pend_nxt;
  logic                use_border_r, use_border_nxt;
  logic [CORNER_W-1:0] corner_r, corner_nxt;
  logic [VIDX_W-1:0]   vcnt_r, vcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VIDX_W-1:0]   out_vidx_r;
  vfcm_vtx_t           out_vtx_r;
  logic [FACE_W-1:0]   out_face_r;
  logic                out_last_r;

  // neighbour addressing for face_r
  logic [CMP_W-1:0]     cw_x, cw_y, cw_z, nw_x, nw_y, nw_z;
  logic                 face_lo;
  logic                 nb_edge;
  logic [CUBE_AW-1:0]   ctr_addr, nb_addr;
  logic [BORDER_AW-1:0] nb_plane_addr;

  always_comb begin
    cw_x    = CMP_W'(cx_r);
    cw_y    = CMP_W'(cy_r);
    cw_z    = CMP_W'(cz_r);
    nw_x    = cw_x;
    nw_y    = cw_y;
    nw_z    = cw_z;
    face_lo = face_r < FACE_PX;
    case (face_axis(face_r))
      AXIS_X: begin
        nb_edge = face_lo ? (cw_x == '0) : (cw_x == EDGE_M1);
        nw_x    = face_lo ? cw_x - CMP_W'(1) : cw_x + CMP_W'(1);
      end
      AXIS_Y: begin
        nb_edge = face_lo ? (cw_y == '0) : (cw_y == EDGE_M1);
        nw_y    = face_lo ? cw_y - CMP_W'(1) : cw_y + CMP_W'(1);
      end
      default: begin
        nb_edge = face_lo ? (cw_z == '0) : (cw_z == EDGE_M1);
        nw_z    = face_lo ? cw_z - CMP_W'(1) : cw_z + CMP_W'(1);
      end
    endcase
    ctr_addr      = cube_addr(cw_x, cw_y, cw_z);
    nb_addr       = cube_addr(nw_x, nw_y, nw_z);
    nb_plane_addr = plane_addr(face_r, cw_x, cw_y, cw_z);
  end

  // cell stores
  logic [ID_W-1:0]      chunk_rdata, border_rdata;
  logic                 chunk_we, border_we;
  logic [CUBE_AW-1:0]   chunk_raddr;

  assign chunk_we    = in_fire && (in_kind == KIND_CHUNK_WR) && in_range;
  assign border_we   = in_fire && (in_kind == KIND_BORDER_WR) && in_range &&
                       (in_side <= FACE_PZ);
  assign chunk_raddr = (state_r == S_NB_RD) ? nb_addr : ctr_addr;

  vfcm_ram #(
    .WIDTH (ID_W),
    .DEPTH (CUBE_DEPTH)
  ) u_chunk_ram (
    .clk   (clk),
    .we    (chunk_we),
    .waddr (cube_addr(in_wx, in_wy, in_wz)),
    .wdata (in_value),
    .raddr (chunk_raddr),
    .rdata (chunk_rdata)
  );

  vfcm_ram #(
    .WIDTH (ID_W),
    .DEPTH (BORDER_DEPTH)
  ) u_border_ram (
    .clk   (clk),
    .we    (border_we),
    .waddr (plane_addr(in_side, in_wx, in_wy, in_wz)),
    .wdata (in_value),
    .raddr (nb_plane_addr),
    .rdata (border_rdata)
  );

  // lowest pending face and what stays after it
  logic [FACE_W-1:0]    cur_face;
  logic [NUM_FACES-1:0] pend_left;

  always_comb begin
    cur_face = FACE_NX;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        cur_face = FACE_W'(i);
      end
    end
    for (int i = 0; i < NUM_FACES; i++) begin
      pend_left[i] = pend_r[i] && (FACE_W'(i) != cur_face);
    end
  end

  vfcm_vtx_req_t vtx_req;
  vfcm_vtx_t     vtx;

  assign vtx_req = '{face: cur_face, corner: corner_r, blk: blk_r,
                     cx: cx_r, cy: cy_r, cz: cz_r};

  vfcm_vertex #(
    .CHUNK_EDGE (CHUNK_EDGE)
  ) u_vertex (
    .cfg (cfg_r),
    .req (vtx_req),
    .vtx (vtx)
  );

  logic            emit_fire;
  logic [ID_W-1:0] nb_value;

  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign nb_value  = use_border_r ? border_rdata : chunk_rdata;

  always_comb begin
    state_nxt      = state_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    blk_nxt        = blk_r;
    face_nxt       = face_r;
    pend_nxt       = pend_r;
    use_border_nxt = use_border_r;
    corner_nxt     = corner_r;
    vcnt_nxt       = vcnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_START: vcnt_nxt = '0;
            KIND_MESH: begin
              if (in_range) begin
                cx_nxt    = in_cx;
                cy_nxt    = in_cy;
                cz_nxt    = in_cz;
                state_nxt = S_CELL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_CELL_RD: state_nxt = S_CELL_CHK;
      S_CELL_CHK: begin
        // drop air cells
        if (chunk_rdata == cfg_r.air) begin
          state_nxt = S_IDLE;
        end else begin
          blk_nxt   = chunk_rdata;
          face_nxt  = FACE_NX;
          pend_nxt  = '0;
          state_nxt = S_NB_RD;
        end
      end
      S_NB_RD: begin
        use_border_nxt = nb_edge;
        state_nxt      = S_NB_CHK;
      end
      S_NB_CHK: begin
        for (int i = 0; i < NUM_FACES; i++) begin
          if ((FACE_W'(i) == face_r) && (nb_value == cfg_r.air)) begin
            pend_nxt[i] = 1'b1;
          end
        end
        if (face_r == FACE_PZ) begin
          corner_nxt = '0;
          state_nxt  = (pend_nxt == '0) ? S_IDLE : S_EMIT;
        end else begin
          face_nxt  = face_r + FACE_W'(1);
          state_nxt = S_NB_RD;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt = 1'b1;
          vcnt_nxt      = vcnt_r + VIDX_W'(1);
          corner_nxt    = corner_r + CORNER_W'(1);
          if (corner_r == 2'd3) begin
            pend_nxt = pend_left;
            if (pend_left == '0) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    cz_r         <= cz_nxt;
    blk_r        <= blk_nxt;
    face_r       <= face_nxt;
    use_border_r <= use_border_nxt;
    corner_r     <= corner_nxt;
    if (emit_fire) begin
      out_vidx_r <= vcnt_r;
      out_vtx_r  <= vtx;
      out_face_r <= cur_face;
      out_last_r <= (corner_r == 2'd3) && (pend_left == '0);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_face_r, out_vtx_r.tex_v, out_vtx_r.tex_column,
                       out_vtx_r.shade, out_vtx_r.pos_z, out_vtx_r.pos_y,
                       out_vtx_r.pos_x, out_vidx_r};

`ifndef SYNTHESIS
  a_short_item_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != KIND_MESH)) |=> in_tready)
    else $error("write or start item did not finish in one cycle");

  a_emit_has_face: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (pend_r != '0))
    else $error("vertex output with no face pending");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (vcnt_r == VIDX_W'($past(vcnt_r) + VIDX_W'(1))))
    else $error("vertex counter did not advance by one per vertex");
`endif

endmodule

`default_nettype wire

[rtl/vfcm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module vfcm_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/vfcm_vertex.sv]
// Vertex formatter: position, shade and texture column of one face corner.
// Depends on vfcm_pkg.
`default_nettype none

module vfcm_vertex
  import vfcm_pkg::*;
#(
  parameter int CHUNK_EDGE = CHUNK_EDGE_DEF
) (
  input  wire vfcm_cfg_t     cfg,
  input  wire vfcm_vtx_req_t req,
  output vfcm_vtx_t          vtx
);

  localparam logic [POS_W-1:0] EDGE_P = POS_W'(CHUNK_EDGE);

  // 2 * (cell + edge * chunk position) +/- 1, modulo 2^POS_W
  function automatic logic [POS_W-1:0] axis_pos(input logic [CELL_W-1:0] c,
                                                input logic [CPOS_W-1:0] p,
                                                input logic              up);
    logic [POS_W-1:0] p_ext;
    logic [POS_W-1:0] base;
    p_ext = {{(POS_W-CPOS_W){p[CPOS_W-1]}}, p};
    base  = (POS_W'(c) + p_ext * EDGE_P) << 1;
    return up ? base + POS_W'(1) : base - POS_W'(1);
  endfunction

  logic [2:0]      signs;
  logic [ID_W-1:0] tex;
  logic            right;

  always_comb begin
    signs = corner_signs(req.face, req.corner);
    tex   = req.blk;
    if (req.blk == cfg.grass) begin
      if (req.face == FACE_PY) begin
        tex = cfg.grass_top;
      end else if (req.face == FACE_NY) begin
        tex = cfg.dirt;
      end
    end
    right = (req.corner == 2'd1) || (req.corner == 2'd2);

    vtx.pos_x      = axis_pos(req.cx, cfg.pos_x, signs[0]);
    vtx.pos_y      = axis_pos(req.cy, cfg.pos_y, signs[1]);
    vtx.pos_z      = axis_pos(req.cz, cfg.pos_z, signs[2]);
    vtx.shade      = face_shade(req.face);
    vtx.tex_column = right ? TEX_W'(tex) : TEX_W'(tex) - TEX_W'(1);
    vtx.tex_v      = ~req.corner[1];
  end

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for voxel_face_cull_mesher: loads cells and borders, meshes
// cells and checks every vertex against an in-bench copy of the block's behaviour.
// Depends on vfcm_pkg and the RTL of the mesher only.

module testbench;
  import vfcm_pkg::*;

  localparam int EDGE          = CHUNK_EDGE_DEF;
  localparam int CUBE          = EDGE * EDGE * EDGE;
  localparam int PLANE         = EDGE * EDGE;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPEAT_MESHES = 30;     // 24 vertices each, back to back

  typedef struct {
    logic [VIDX_W-1:0]  index;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [POS_W-1:0]   pz;
    logic [SHADE_W-1:0] shade;
    logic [TEX_W-1:0]   column;
    logic               tv;
    logic [FACE_W-1:0]  face;
    logic               last;
  } vertex_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // chunk cells first, then the six border planes
  logic [ID_W-1:0]          cell_ids [CUBE + NUM_FACES * PLANE];
  bit                       cell_written [CUBE + NUM_FACES * PLANE];
  logic [VIDX_W-1:0]        vertex_count;
  logic [ID_W-1:0]          air_reg, grass_reg, top_reg, dirt_reg;
  logic signed [CPOS_W-1:0] cpos [3];
  vertex_t                  pending_vertices [$];
  int                       mismatch_count;
  int                       items_sent;
  int                       quiet_cycles;
  bit                       gaps_on;
  bit                       stalls_on;

  voxel_face_cull_mesher #(.CHUNK_EDGE(EDGE)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // result side: random stall bursts while enabled
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  function automatic int cube_slot(int x, int y, int z);
    return (x * EDGE + y) * EDGE + z;
  endfunction

  // a plane is addressed by the two coordinates off its own axis
  function automatic int border_slot(int side, int x, int y, int z);
    int axis, a, b;
    axis = side % 3;
    a = (axis == 0) ? y : x;
    b = (axis == 2) ? y : z;
    return CUBE + side * PLANE + a * EDGE + b;
  endfunction

  function automatic int neighbour_slot(int f, int x, int y, int z);
    int axis;
    int c [3];
    axis = f % 3;
    c[0] = x;
    c[1] = y;
    c[2] = z;
    if (f < 3) begin
      if (c[axis] == 0) return border_slot(f, x, y, z);
      c[axis] = c[axis] - 1;
    end else begin
      if (c[axis] == EDGE - 1) return border_slot(f, x, y, z);
      c[axis] = c[axis] + 1;
    end
    return cube_slot(c[0], c[1], c[2]);
  endfunction

  // true when meshing this cell reads only entries that have been written
  function automatic bit mesh_is_safe(int x, int y, int z);
    int s, f;
    s = cube_slot(x, y, z);
    if (!cell_written[s]) return 1'b0;
    if (cell_ids[s] == air_reg) return 1'b1;
    for (f = 0; f < NUM_FACES; f++) begin
      if (!cell_written[neighbour_slot(f, x, y, z)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [SHADE_W-1:0] face_light(int f);
    case (f)
      FACE_NX: return 4'd7;
      FACE_NY: return 4'd4;
      FACE_NZ: return 4'd6;
      FACE_PX: return 4'd7;
      FACE_PY: return 4'd10;
      default: return 4'd8;
    endcase
  endfunction

  // update the stores for one accepted item and queue the vertices it yields
  task automatic compute_vertices(vfcm_kind_t kind, int x, int y, int z, int side,
                                  logic [ID_W-1:0] val);
    int s, f, k, axis, hz, vt;
    int ofs [3];
    int base [3];
    logic [ID_W-1:0] blk, tex;
    bit [NUM_FACES-1:0] visible;
    bit right;
    vertex_t v;
    case (kind)
      KIND_START: vertex_count = '0;
      KIND_CHUNK_WR: begin
        s = cube_slot(x, y, z);
        cell_ids[s] = val;
        cell_written[s] = 1'b1;
      end
      KIND_BORDER_WR: begin
        if (side < NUM_FACES) begin
          s = border_slot(side, x, y, z);
          cell_ids[s] = val;
          cell_written[s] = 1'b1;
        end
      end
      default: begin
        blk = cell_ids[cube_slot(x, y, z)];
        if (blk != air_reg) begin
          base[0] = 2 * (x + EDGE * int'(cpos[0]));
          base[1] = 2 * (y + EDGE * int'(cpos[1]));
          base[2] = 2 * (z + EDGE * int'(cpos[2]));
          for (f = 0; f < NUM_FACES; f++) begin
            visible[f] = (cell_ids[neighbour_slot(f, x, y, z)] == air_reg);
          end
          for (f = 0; f < NUM_FACES; f++) begin
            if (visible[f]) begin
              tex = blk;
              if (blk == grass_reg && f == FACE_PY) tex = top_reg;
              else if (blk == grass_reg && f == FACE_NY) tex = dirt_reg;
              // corners sweep the face: across is z on x faces and x otherwise,
              // upward is z on y faces and y otherwise
              axis = f % 3;
              hz = (axis == 0) ? 2 : 0;
              vt = (axis == 1) ? 2 : 1;
              for (k = 0; k < 4; k++) begin
                right = (k == 1 || k == 2);
                ofs[axis] = (f < 3) ? -1 : 1;
                ofs[hz] = right ? 1 : -1;
                ofs[vt] = (k < 2) ? 1 : -1;
                v.index = vertex_count;
                v.px = POS_W'(base[0] + ofs[0]);
                v.py = POS_W'(base[1] + ofs[1]);
                v.pz = POS_W'(base[2] + ofs[2]);
                v.shade = face_light(f);
                v.column = right ? {1'b0, tex} : {1'b0, tex} - 9'd1;
                v.tv = (k < 2);
                v.face = FACE_W'(f);
                v.last = (k == 3) && ((visible >> (f + 1)) == 0);
                pending_vertices.insert(pending_vertices.size(), v);
                vertex_count = vertex_count + VIDX_W'(1);
              end
            end
          end
        end
      end
    endcase
  endtask

  task automatic send_item(vfcm_kind_t kind, int x, int y, int z, int side, int val);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, 8'(val), 3'(side), 4'(z), 4'(y), 4'(x)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    compute_vertices(kind, x, y, z, side, 8'(val));
    items_sent++;
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_vertices.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(posedge clk);
    case (idx)
      REG_AIR:       air_reg = 8'(data);
      REG_GRASS:     grass_reg = 8'(data);
      REG_GRASS_TOP: top_reg = 8'(data);
      REG_DIRT:      dirt_reg = 8'(data);
      REG_POS_X:     cpos[0] = CPOS_W'(data);
      REG_POS_Y:     cpos[1] = CPOS_W'(data);
      default:       cpos[2] = CPOS_W'(data);
    endcase
  endtask

  // drain, let a faceless mesh finish, then reprogram every register
  task automatic set_config(int air, int grass, int top, int dirt, int px, int py, int pz);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_AIR, air);
    write_reg(REG_GRASS, grass);
    write_reg(REG_GRASS_TOP, top);
    write_reg(REG_DIRT, dirt);
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_POS_Z, pz);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_block();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return int'(air_reg);
    if (r < 6) return int'(grass_reg);
    if (r == 6) return 0;
    if (r == 7) return 255;
    return $urandom_range(0, 255);
  endfunction

  // edges are favoured so that the border planes get plenty of use
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 0;
    if (r < 6) return EDGE - 1;
    return $urandom_range(0, EDGE - 1);
  endfunction

  task automatic mesh_cell(int x, int y, int z);
    send_item(KIND_MESH, x, y, z, $urandom_range(0, 7), $urandom_range(0, 255));
  endtask

  // write a cell and the six entries its faces look at
  task automatic build_cell(int x, int y, int z, int blk, bit open_air);
    int f, axis, val;
    int c [3];
    send_item(KIND_CHUNK_WR, x, y, z, $urandom_range(0, 7), blk);
    for (f = 0; f < NUM_FACES; f++) begin
      axis = f % 3;
      c[0] = x;
      c[1] = y;
      c[2] = z;
      val = open_air ? int'(air_reg) : pick_block();
      if ((f < 3 && c[axis] == 0) || (f >= 3 && c[axis] == EDGE - 1)) begin
        // the plane ignores its own axis, so scramble that coordinate
        c[axis] = $urandom_range(0, EDGE - 1);
        send_item(KIND_BORDER_WR, c[0], c[1], c[2], f, val);
      end else begin
        c[axis] = (f < 3) ? c[axis] - 1 : c[axis] + 1;
        send_item(KIND_CHUNK_WR, c[0], c[1], c[2], $urandom_range(0, 7), val);
      end
    end
  endtask

  task automatic run_traffic(int count);
    int goal, r, x, y, z, blk;
    goal = items_sent + count;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      x = pick_coord();
      y = pick_coord();
      z = pick_coord();
      if (r < 65) begin
        blk = $urandom_range(0, 1) ? int'(grass_reg) : $urandom_range(0, 255);
        build_cell(x, y, z, blk, $urandom_range(0, 3) == 0);
        mesh_cell(x, y, z);
      end else if (r < 80) begin
        if (mesh_is_safe(x, y, z)) mesh_cell(x, y, z);
      end else if (r < 88) begin
        send_item(KIND_CHUNK_WR, x, y, z, $urandom_range(0, 7), pick_block());
      end else if (r < 94) begin
        send_item(KIND_BORDER_WR, x, y, z, $urandom_range(0, 7), pick_block());
      end else if (r < 97) begin
        send_item(KIND_START, x, y, z, $urandom_range(0, 7), $urandom_range(0, 255));
      end else begin
        pause_until_drained();
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : check_vertices
    vertex_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected vertex index", 32'(out_tdata[15:0]), 32'd0);
      end else begin
        want = pending_vertices.pop_front();
        check_field("vertex_index", 32'(out_tdata[15:0]), 32'(want.index));
        check_field("pos_x_half", 32'(out_tdata[33:16]), 32'(want.px));
        check_field("pos_y_half", 32'(out_tdata[51:34]), 32'(want.py));
        check_field("pos_z_half", 32'(out_tdata[69:52]), 32'(want.pz));
        check_field("shade_tenths", 32'(out_tdata[73:70]), 32'(want.shade));
        check_field("tex_column", 32'(out_tdata[82:74]), 32'(want.column));
        check_field("tex_v", 32'(out_tdata[83]), 32'(want.tv));
        check_field("face_dir", 32'(out_tdata[86:84]), 32'(want.face));
        check_field("pad bit", 32'(out_tdata[87]), 32'd0);
        check_field("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  // reset defaults: grass top and bottom, full edge cell, culling, ignored writes
  task automatic test_directed_cases();
    build_cell(0, 0, 0, int'(grass_reg), 1'b1);
    mesh_cell(0, 0, 0);
    build_cell(EDGE - 1, EDGE - 1, EDGE - 1, 255, 1'b0);
    mesh_cell(EDGE - 1, EDGE - 1, EDGE - 1);
    mesh_cell(1, 0, 0);
    send_item(KIND_BORDER_WR, 3, 4, 5, 6, 165);
    send_item(KIND_BORDER_WR, 15, 0, 10, 7, 90);
    send_item(KIND_START, 9, 6, 3, 2, 255);
    send_item(KIND_CHUNK_WR, 0, 0, 0, 0, 1);
    mesh_cell(0, 0, 0);
  endtask

  task automatic test_default_config();
    run_traffic(140);
  endtask

  // lowest positions, air at the top id, dirt id zero gives column -1
  task automatic test_extreme_config();
    set_config(255, 0, 255, 0, -2048, -2048, -2048);
    run_traffic(110);
  endtask

  task automatic test_far_corner_config();
    set_config(0, 255, 0, 255, 2047, 2047, 2047);
    run_traffic(110);
  endtask

  // mesh one open cell again and again with no start between, so the index keeps running
  task automatic test_repeat_mesh();
    int x, y, z, i;
    set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095));
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    x = pick_coord();
    y = pick_coord();
    z = pick_coord();
    build_cell(x, y, z, int'(air_reg ^ 8'h5A), 1'b1);
    send_item(KIND_START, x, y, z, 0, 0);
    for (i = 0; i < REPEAT_MESHES; i++) mesh_cell(x, y, z);
  endtask

  task automatic test_quiet_mixed_config();
    set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), -2048, 2047, $urandom_range(0, 4095));
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_traffic(100);
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_START;
    cfg_we    <= 1'b0;
    cfg_index <= REG_AIR;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    vertex_count = '0;
    air_reg   = AIR_RST;
    grass_reg = GRASS_RST;
    top_reg   = GRASS_TOP_RST;
    dirt_reg  = DIRT_RST;
    cpos[0] = '0;
    cpos[1] = '0;
    cpos[2] = '0;
    mismatch_count = 0;
    items_sent = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_default_config();
    test_extreme_config();
    test_far_corner_config();
    test_repeat_mesh();
    test_quiet_mixed_config();

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
